[sv/pfga_pkg.sv]
// Package for the particle footprint grid average block.
// Holds payload structs, request and register codes, and arithmetic constants.
// No dependencies.
package pfga_pkg;

  localparam int unsigned POS_W = 48;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned LOG_W = 24;
  localparam int unsigned HIT_W = 16;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned ACC_W = 100;

  localparam logic [1:0] REQ_DEPOSIT = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam logic [2:0] CFG_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z   = 3'd2;
  localparam logic [2:0] CFG_HALF_WIDTH = 3'd3;
  localparam logic [2:0] CFG_CELL_SCALE = 3'd4;
  localparam logic [2:0] CFG_MAP_MODE   = 3'd5;
  localparam logic [2:0] CFG_CLAMP_LOW  = 3'd6;
  localparam logic [2:0] CFG_CLAMP_HIGH = 3'd7;

  localparam logic [POS_W-1:0] CLAMP_LOW_RST  = 48'd10000000000;
  localparam logic [POS_W-1:0] CLAMP_HIGH_RST = 48'd1000000000000;
  localparam logic [31:0]      LOG10_2_Q28    = 32'd80807124;

  localparam logic [1:0] MAC_SH0  = 2'd0;
  localparam logic [1:0] MAC_SH32 = 2'd1;
  localparam logic [1:0] MAC_SH64 = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [POS_W-1:0] smooth_len;
    logic [POS_W-1:0] deposit_value;
    logic [IDX_W-1:0] cell_row;
    logic [IDX_W-1:0] cell_col;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_out;
    logic [IDX_W-1:0] col_out;
    logic [LOG_W-1:0] log_average;
    logic [HIT_W-1:0] hit_count;
  } out_t;

  typedef struct packed {
    logic        en;
    logic        clr;
    logic [31:0] a;
    logic [31:0] b;
    logic [1:0]  sh;
  } mac_ctl_t;

endpackage

[sv/particle_footprint_grid_average.sv]
// Particle footprint grid average, top level: sequencer, config registers,
// output register. Depends on pfga_pkg, pfga_mem, pfga_mac, pfga_div.
//
// Input channel in_valid_i/in_ready_o carries one request (deposit, read,
// clear). Output channel out_valid_o/out_ready_i carries one result per
// in-grid read request. cfg_we_i writes one register per cycle by index.
// One request is worked at a time; in_ready_o is high only when idle.
// Deposit: setup (cube test, walk start), an index multiply on the shared
// 32x32 MAC per footprint bound, then a read and a write per covered cell.
// Read: memory read, divider, normalize, squaring on the shared MAC, then
// scaling. Clear: one memory entry per cycle, GRID_SIZE*GRID_SIZE entries.
// After reset the same clearing pass runs before the first transfer is
// taken; config writes are taken meanwhile.
// A finished read result sits in the output register; the block takes
// new requests while it waits, and a next read result holds back until
// the receiver takes the first.
module particle_footprint_grid_average import pfga_pkg::*; #(
  parameter int unsigned GRID_SIZE = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [POS_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int unsigned ADRW  = $clog2(DEPTH);
  localparam int unsigned AW    = $clog2(GRID_SIZE);
  localparam int unsigned IW    = AW + 1;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_INSIDE = 5'd2;
  localparam logic [4:0] S_RANGE  = 5'd3;
  localparam logic [4:0] S_MUL    = 5'd4;
  localparam logic [4:0] S_CELLQ  = 5'd5;
  localparam logic [4:0] S_WSTART = 5'd6;
  localparam logic [4:0] S_RD     = 5'd7;
  localparam logic [4:0] S_WR     = 5'd8;
  localparam logic [4:0] S_RRD    = 5'd9;
  localparam logic [4:0] S_RWAIT  = 5'd10;
  localparam logic [4:0] S_DIV    = 5'd11;
  localparam logic [4:0] S_CLAMP  = 5'd12;
  localparam logic [4:0] S_NORM   = 5'd13;
  localparam logic [4:0] S_SQ     = 5'd14;
  localparam logic [4:0] S_SQF    = 5'd15;
  localparam logic [4:0] S_LMUL   = 5'd16;
  localparam logic [4:0] S_LFIN   = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;

  logic [4:0] state_q;

  logic [POS_W-1:0] cx_q, cy_q, cz_q, hw_q, cs_q, clo_q, chi_q;
  logic             mode_q;

  in_t              req_q;
  logic [1:0]       k_q, step_q;
  logic [49:0]      d_q;
  logic [IW-1:0]    r0_q, r1_q, c0_q, c1_q;
  logic             empty_q;
  logic [AW-1:0]    r_q, c_q;
  logic [ADRW-1:0]  clr_adr_q;
  logic [HIT_W-1:0] hits_q;
  logic [POS_W-1:0] x_q;
  logic [5:0]       e_q;
  logic [31:0]      m_q;
  logic [27:0]      frac_q;
  logic [4:0]       it_q;
  logic [LOG_W-1:0] lg_q;
  out_t             out_q;

  mac_ctl_t         mac_ctl;
  logic [ACC_W-1:0] acc;
  logic             div_start, div_busy;
  logic [SUM_W-1:0] quo;

  logic             mem_we, mem_re;
  logic [ADRW-1:0]  mem_waddr, mem_raddr;
  logic [SUM_W-1:0] mem_wsum, rsum;
  logic [HIT_W-1:0] mem_whits, rhits;

  function automatic logic [ADRW-1:0] cell_adr(logic [AW-1:0] r, logic [AW-1:0] c);
    cell_adr = ADRW'(r) * ADRW'(GRID_SIZE) + ADRW'(c);
  endfunction

  function automatic logic in_cube(logic [POS_W-1:0] p, logic [POS_W-1:0] c,
                                   logic [POS_W-1:0] h);
    logic [POS_W-1:0] diff;
    diff = (p >= c) ? p - c : c - p;
    in_cube = diff < h;
  endfunction

  // footprint offset for bound k: rows or columns, low or high edge
  logic [POS_W-1:0] ax_p, ax_c;
  logic signed [50:0] off;
  always_comb begin
    if (!k_q[1]) begin
      ax_p = mode_q ? req_q.pos_z : req_q.pos_x;
      ax_c = mode_q ? cz_q : cx_q;
    end else begin
      ax_p = mode_q ? req_q.pos_y : req_q.pos_z;
      ax_c = mode_q ? cy_q : cz_q;
    end
    off = $signed({3'b0, ax_p}) - $signed({3'b0, ax_c}) + $signed({3'b0, hw_q});
    off = k_q[0] ? off + $signed({3'b0, req_q.smooth_len})
                 : off - $signed({3'b0, req_q.smooth_len});
  end

  logic [35:0]   q_raw;
  logic [IW-1:0] q_cl;
  assign q_raw = acc[ACC_W-1:64];
  assign q_cl  = (q_raw > 36'(GRID_SIZE)) ? IW'(GRID_SIZE) : IW'(q_raw);

  logic [32:0]      sq_t;
  logic [33:0]      l2;
  logic [60:0]      lprod;
  logic [60:0]      lrnd;
  logic [SUM_W-1:0] avg_raw;
  logic [SUM_W-1:0] avg_lo;
  logic [POS_W-1:0] avg_cl;
  logic             corner_lo, corner_hi;
  logic [SUM_W:0]   sum_add;
  assign sq_t  = acc[63:31];
  assign l2    = {e_q, frac_q};
  assign lprod = acc[60:0];
  assign lrnd  = (lprod + 61'(64'd1 << 37)) >> 38;
  assign avg_raw = (hits_q == '0) ? '0 : quo;
  assign avg_lo  = (avg_raw < SUM_W'(clo_q)) ? SUM_W'(clo_q) : avg_raw;
  assign avg_cl  = (avg_lo > SUM_W'(chi_q)) ? chi_q : avg_lo[POS_W-1:0];
  assign corner_lo = (req_q.cell_row == '0) && (req_q.cell_col == '0);
  assign corner_hi = (req_q.cell_row == IDX_W'(GRID_SIZE - 1)) &&
                     (req_q.cell_col == IDX_W'(GRID_SIZE - 1));
  assign sum_add = {1'b0, rsum} + (SUM_W + 1)'(req_q.deposit_value);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_data_o  = out_q;

  always_comb begin
    mac_ctl   = '0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cell_adr(r_q, c_q);
    mem_raddr = cell_adr(r_q, c_q);
    mem_wsum  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    mem_whits = (rhits == '1) ? rhits : rhits + 16'd1;
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_adr_q;
        mem_wsum  = '0;
        mem_whits = '0;
      end
      S_MUL: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (step_q == 2'd0);
        mac_ctl.a   = step_q[1] ? 32'(d_q[49:32]) : d_q[31:0];
        mac_ctl.b   = step_q[0] ? 32'(cs_q[47:32]) : cs_q[31:0];
        mac_ctl.sh  = (step_q == 2'd0) ? MAC_SH0 :
                      (step_q == 2'd3) ? MAC_SH64 : MAC_SH32;
      end
      S_RD:  mem_re = 1'b1;
      S_WR:  mem_we = 1'b1;
      S_RRD: begin
        mem_re    = 1'b1;
        mem_raddr = cell_adr(AW'(req_q.cell_row), AW'(req_q.cell_col));
      end
      S_RWAIT: div_start = 1'b1;
      S_SQ: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_ctl.a   = m_q;
        mac_ctl.b   = m_q;
        mac_ctl.sh  = MAC_SH0;
      end
      S_LMUL: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (step_q == 2'd0);
        mac_ctl.a   = step_q[0] ? 32'(l2[33:32]) : l2[31:0];
        mac_ctl.b   = LOG10_2_Q28;
        mac_ctl.sh  = step_q[0] ? MAC_SH32 : MAC_SH0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      hw_q   <= '0;
      cs_q   <= '0;
      mode_q <= 1'b0;
      clo_q  <= CLAMP_LOW_RST;
      chi_q  <= CLAMP_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:   cx_q   <= cfg_data_i;
        CFG_CENTER_Y:   cy_q   <= cfg_data_i;
        CFG_CENTER_Z:   cz_q   <= cfg_data_i;
        CFG_HALF_WIDTH: hw_q   <= cfg_data_i;
        CFG_CELL_SCALE: cs_q   <= cfg_data_i;
        CFG_MAP_MODE:   mode_q <= cfg_data_i[0];
        CFG_CLAMP_LOW:  clo_q  <= cfg_data_i;
        CFG_CLAMP_HIGH: chi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_adr_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && (state_q != S_OUT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_adr_q <= clr_adr_q + ADRW'(1);
          if (clr_adr_q == ADRW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (in_data_i.req_type)
              REQ_DEPOSIT: state_q <= S_INSIDE;
              REQ_READ: begin
                if (({1'b0, in_data_i.cell_row} < (IDX_W + 1)'(GRID_SIZE)) &&
                    ({1'b0, in_data_i.cell_col} < (IDX_W + 1)'(GRID_SIZE))) begin
                  state_q <= S_RRD;
                end
              end
              REQ_CLEAR: begin
                clr_adr_q <= '0;
                state_q   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_INSIDE: begin
          if (in_cube(req_q.pos_x, cx_q, hw_q) && in_cube(req_q.pos_y, cy_q, hw_q) &&
              in_cube(req_q.pos_z, cz_q, hw_q)) begin
            state_q <= S_RANGE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RANGE: begin
          if (off < 0) begin
            state_q <= (k_q == 2'd3) ? S_WSTART : S_RANGE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (step_q == 2'd3) begin
            state_q <= S_CELLQ;
          end
        end
        S_CELLQ: state_q <= (k_q == 2'd3) ? S_WSTART : S_RANGE;
        S_WSTART: begin
          if (empty_q || (r0_q > r1_q) || (c0_q > c1_q)) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if ((IW'(c_q) == c1_q) && (IW'(r_q) == r1_q)) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RRD:   state_q <= S_RWAIT;
        S_RWAIT: state_q <= S_DIV;
        S_DIV: begin
          if (!div_busy) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: state_q <= S_NORM;
        S_NORM: begin
          if (x_q == '0) begin
            state_q <= S_OUT;
          end else if (x_q[POS_W-1]) begin
            state_q <= S_SQ;
          end
        end
        S_SQ:  state_q <= S_SQF;
        S_SQF: state_q <= (it_q == 5'd27) ? S_LMUL : S_SQ;
        S_LMUL: begin
          if (step_q == 2'd1) begin
            state_q <= S_LFIN;
          end
        end
        S_LFIN: state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        req_q   <= in_data_i;
        k_q     <= '0;
        step_q  <= '0;
        empty_q <= 1'b0;
      end
      S_RANGE: begin
        step_q <= '0;
        if (off < 0) begin
          k_q <= k_q + 2'd1;
          unique case (k_q)
            2'd0:    r0_q <= '0;
            2'd2:    c0_q <= '0;
            default: empty_q <= 1'b1;
          endcase
        end else begin
          d_q <= off[49:0];
        end
      end
      S_MUL: step_q <= step_q + 2'd1;
      S_CELLQ: begin
        k_q <= k_q + 2'd1;
        unique case (k_q)
          2'd0: r0_q <= q_cl;
          2'd1: r1_q <= (q_cl > IW'(GRID_SIZE - 1)) ? IW'(GRID_SIZE - 1) : q_cl;
          2'd2: c0_q <= q_cl;
          default: c1_q <= (q_cl > IW'(GRID_SIZE - 1)) ? IW'(GRID_SIZE - 1) : q_cl;
        endcase
      end
      S_WSTART: begin
        r_q <= AW'(r0_q);
        c_q <= AW'(c0_q);
      end
      S_WR: begin
        if (IW'(c_q) == c1_q) begin
          c_q <= AW'(c0_q);
          r_q <= r_q + AW'(1);
        end else begin
          c_q <= c_q + AW'(1);
        end
      end
      S_RWAIT: hits_q <= rhits;
      S_CLAMP: begin
        x_q    <= corner_lo ? clo_q : corner_hi ? chi_q : avg_cl;
        e_q    <= 6'd47;
        lg_q   <= '0;
        step_q <= '0;
      end
      S_NORM: begin
        if (x_q[POS_W-1]) begin
          m_q    <= x_q[47:16];
          frac_q <= '0;
          it_q   <= '0;
        end else if (x_q != '0) begin
          x_q <= x_q << 1;
          e_q <= e_q - 6'd1;
        end
      end
      S_SQF: begin
        frac_q <= {frac_q[26:0], sq_t[32]};
        m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        it_q   <= it_q + 5'd1;
      end
      S_LMUL: step_q <= step_q + 2'd1;
      S_LFIN: lg_q <= (lrnd > 61'hFFFFFF) ? '1 : lrnd[LOG_W-1:0];
      S_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          out_q.row_out     <= req_q.cell_row;
          out_q.col_out     <= req_q.cell_col;
          out_q.log_average <= lg_q;
          out_q.hit_count   <= hits_q;
        end
      end
      default: ;
    endcase
  end

  pfga_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .acc_o (acc)
  );

  pfga_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rsum),
    .den_i   (rhits),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  pfga_mem #(
    .DEPTH (DEPTH),
    .ADRW  (ADRW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wsum_i  (mem_wsum),
    .whits_i (mem_whits),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rsum_o  (rsum),
    .rhits_o (rhits)
  );

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_data_i.req_type == REQ_DEPOSIT || in_data_i.req_type == REQ_CLEAR)
    |=> !in_ready_o)
    else $error("ready held after input transfer");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("cell store written while idle");

  a_div_only_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider running outside read");

  a_out_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

endmodule

[sv/pfga_mem.sv]
// Cell store: per-cell 64-bit sums and 16-bit hit counts.
// One write port, one read port with registered read data. Uses pfga_pkg.
module pfga_mem import pfga_pkg::*; #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned ADRW  = 18
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ADRW-1:0]  waddr_i,
  input  logic [SUM_W-1:0] wsum_i,
  input  logic [HIT_W-1:0] whits_i,
  input  logic             re_i,
  input  logic [ADRW-1:0]  raddr_i,
  output logic [SUM_W-1:0] rsum_o,
  output logic [HIT_W-1:0] rhits_o
);

  logic [SUM_W-1:0] sum_mem  [DEPTH];
  logic [HIT_W-1:0] hits_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      sum_mem[waddr_i]  <= wsum_i;
      hits_mem[waddr_i] <= whits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rsum_o  <= sum_mem[raddr_i];
      rhits_o <= hits_mem[raddr_i];
    end
  end

endmodule

[sv/pfga_mac.sv]
// Shared 32x32 multiply-accumulate unit with a shifted accumulate.
// Serves partial products, squaring and the log scale. Uses pfga_pkg.
module pfga_mac import pfga_pkg::*; (
  input  logic             clk_i,
  input  mac_ctl_t         ctl_i,
  output logic [ACC_W-1:0] acc_o
);

  logic [63:0]      prod;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] base;

  assign prod = 64'(ctl_i.a) * 64'(ctl_i.b);
  assign base = ctl_i.clr ? '0 : acc_o;

  always_comb begin
    unique case (ctl_i.sh)
      MAC_SH32: term = ACC_W'({prod, 32'd0});
      MAC_SH64: term = ACC_W'({prod, 64'd0});
      default:  term = ACC_W'(prod);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_o <= base + term;
    end
  end

endmodule

[sv/pfga_div.sv]
// Restoring divider, one quotient bit per cycle, 64 by 16 bits.
// Uses pfga_pkg.
module pfga_div import pfga_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] num_i,
  input  logic [HIT_W-1:0] den_i,
  output logic             busy_o,
  output logic [SUM_W-1:0] quo_o
);

  logic [HIT_W-1:0] rem_q;
  logic [HIT_W-1:0] den_q;
  logic [6:0]       cnt_q;
  logic [HIT_W:0]   rem_sh;
  logic [HIT_W:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_o[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_o <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_o <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_o) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'(SUM_W - 1)) begin
        busy_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_o <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sub[HIT_W-1:0];
        quo_o <= {quo_o[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[HIT_W-1:0];
        quo_o <= {quo_o[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[sim/particle_footprint_grid_average_test.sv]
// Testbench for particle_footprint_grid_average: directed and random requests,
// predicted in SystemVerilog and checked per result. Depends on pfga_pkg and the RTL.
`timescale 1ns / 100ps

module particle_footprint_grid_average_test;
  import pfga_pkg::*;

  localparam int GRID = 512;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = CFG_CENTER_X;
  logic [POS_W-1:0] cfg_data_i = '0;

  particle_footprint_grid_average #(.GRID_SIZE(GRID)) dut (.*);

  typedef struct {
    logic [POS_W-1:0] cx, cy, cz, hw, scale, lo, hi;
    logic             mode;
  } map_cfg_t;

  map_cfg_t         cfg;
  logic [SUM_W-1:0] sum_store[int];
  logic [HIT_W-1:0] hits_store[int];
  out_t             pending_reads[$];
  int               touched_rows[$], touched_cols[$];
  int               errors = 0;
  int               hold_left = 0;
  bit               no_idle = 0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  function automatic longint cell_of(longint d);
    logic [127:0] prod;
    logic [63:0]  q;
    if (d < 0) return -1;
    prod = 128'(d) * 128'(cfg.scale);
    q = prod[127:64];
    if (q > GRID) return GRID;
    return longint'(q);
  endfunction

  function automatic void axis_span(logic [47:0] p, logic [47:0] c, logic [47:0] h,
                                    output longint lo, output longint hi);
    longint base, a, b;
    base = $signed({16'd0, p}) - $signed({16'd0, c}) + $signed({16'd0, cfg.hw});
    a = cell_of(base - $signed({16'd0, h}));
    b = cell_of(base + $signed({16'd0, h}));
    lo = a < 0 ? 0 : a;
    hi = b > GRID - 1 ? GRID - 1 : b;
  endfunction

  function automatic bit near(logic [47:0] p, logic [47:0] c);
    logic [47:0] diff;
    diff = p >= c ? p - c : c - p;
    return diff < cfg.hw;
  endfunction

  function automatic bit footprint(in_t it, output longint r0, r1, c0, c1);
    r0 = 0; r1 = -1; c0 = 0; c1 = -1;
    if (!near(it.pos_x, cfg.cx) || !near(it.pos_y, cfg.cy) || !near(it.pos_z, cfg.cz))
      return 0;
    if (!cfg.mode) begin
      axis_span(it.pos_x, cfg.cx, it.smooth_len, r0, r1);
      axis_span(it.pos_z, cfg.cz, it.smooth_len, c0, c1);
    end else begin
      axis_span(it.pos_z, cfg.cz, it.smooth_len, r0, r1);
      axis_span(it.pos_y, cfg.cy, it.smooth_len, c0, c1);
    end
    return 1;
  endfunction

  function automatic logic [LOG_W-1:0] log10_fixed(logic [63:0] x);
    int          e;
    logic [63:0] m, frac, l2, prod;
    if (x == 0) return '0;
    e = 63;
    while (!x[e]) e--;
    m = e >= 31 ? x >> (e - 31) : x << (31 - e);
    frac = 0;
    for (int k = 0; k < 28; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    l2 = (64'(e) << 28) | frac;
    prod = l2 * 64'(LOG10_2_Q28);
    prod = (prod + (64'd1 << 37)) >> 38;
    if (prod > 64'hFF_FFFF) prod = 64'hFF_FFFF;
    return prod[LOG_W-1:0];
  endfunction

  function automatic void deposit_footprint(in_t it);
    longint      r0, r1, c0, c1;
    int          idx;
    logic [63:0] s, v;
    if (!footprint(it, r0, r1, c0, c1)) return;
    v = 64'(it.deposit_value);
    for (longint r = r0; r <= r1; r++)
      for (longint c = c0; c <= c1; c++) begin
        idx = int'(r) * GRID + int'(c);
        s = (sum_store.exists(idx) ? sum_store[idx] : 64'd0) + v;
        sum_store[idx] = s < v ? '1 : s;
        if (!hits_store.exists(idx)) hits_store[idx] = '0;
        if (hits_store[idx] != 16'hFFFF) hits_store[idx]++;
      end
    if (r0 <= r1 && c0 <= c1) begin
      touched_rows.push_back(int'(r0)); touched_cols.push_back(int'(c0));
      touched_rows.push_back(int'(r1)); touched_cols.push_back(int'(c1));
      while (touched_rows.size() > 64) begin
        void'(touched_rows.pop_front()); void'(touched_cols.pop_front());
      end
    end
  endfunction

  function automatic void read_cell_expect(in_t it);
    int          idx;
    logic [63:0] avg, s;
    logic [15:0] h;
    out_t        res;
    if (it.cell_row >= GRID || it.cell_col >= GRID) return;
    idx = int'(it.cell_row) * GRID + int'(it.cell_col);
    s = sum_store.exists(idx) ? sum_store[idx] : 64'd0;
    h = hits_store.exists(idx) ? hits_store[idx] : 16'd0;
    avg = h > 0 ? s / h : 64'd0;
    if (avg < cfg.lo) avg = cfg.lo;
    if (avg > cfg.hi) avg = cfg.hi;
    res.log_average = log10_fixed(avg);
    if (it.cell_row == 0 && it.cell_col == 0) res.log_average = log10_fixed(cfg.lo);
    if (it.cell_row == GRID - 1 && it.cell_col == GRID - 1)
      res.log_average = log10_fixed(cfg.hi);
    res.row_out = it.cell_row;
    res.col_out = it.cell_col;
    res.hit_count = h;
    pending_reads.push_back(res);
  endfunction

  // keep footprints small so deposits stay cheap
  function automatic in_t bound_footprint(in_t it);
    longint r0, r1, c0, c1;
    if (it.req_type == REQ_DEPOSIT && footprint(it, r0, r1, c0, c1))
      if (r1 >= r0 && c1 >= c0 && (r1 - r0 + 1) * (c1 - c0 + 1) > 120) it.smooth_len = '0;
    return it;
  endfunction

  task automatic send(in_t it);
    int gap;
    it = bound_footprint(it);
    gap = (!no_idle && $urandom_range(99) < 35) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    case (it.req_type)
      REQ_DEPOSIT: deposit_footprint(it);
      REQ_READ:    read_cell_expect(it);
      REQ_CLEAR: begin
        sum_store.delete();
        hits_store.delete();
        touched_rows.delete();
        touched_cols.delete();
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(map_cfg_t c);
    write_reg(CFG_CENTER_X, c.cx);
    write_reg(CFG_CENTER_Y, c.cy);
    write_reg(CFG_CENTER_Z, c.cz);
    write_reg(CFG_HALF_WIDTH, c.hw);
    write_reg(CFG_CELL_SCALE, c.scale);
    write_reg(CFG_MAP_MODE, {47'd0, c.mode});
    write_reg(CFG_CLAMP_LOW, c.lo);
    write_reg(CFG_CLAMP_HIGH, c.hi);
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  function automatic in_t mk_read(int r, int c);
    in_t it;
    it = '0;
    it.req_type = REQ_READ;
    it.cell_row = r[9:0];
    it.cell_col = c[9:0];
    return it;
  endfunction

  function automatic in_t mk_deposit(logic [47:0] x, logic [47:0] y, logic [47:0] z,
                                     logic [47:0] h, logic [47:0] v);
    in_t it;
    it = '0;
    it.req_type = REQ_DEPOSIT;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.smooth_len = h; it.deposit_value = v;
    return it;
  endfunction

  function automatic logic [47:0] near_center(logic [47:0] c);
    logic [63:0] span;
    if (cfg.hw == 0) return c;
    span = 64'(cfg.hw) * 2;
    return 48'(64'(c) - 64'(cfg.hw) + ({$urandom, $urandom} % span));
  endfunction

  function automatic in_t random_item();
    in_t          it;
    int           k, pick;
    logic [319:0] raw;
    k = $urandom_range(99);
    if (k < 45) begin
      it = mk_deposit(near_center(cfg.cx), near_center(cfg.cy), near_center(cfg.cz),
                      (48'($urandom_range(0, 3)) << 32) | 48'($urandom),
                      $urandom_range(1) ? 48'({$urandom_range(1, 500), 30'd0}) : rand48());
    end else if (k < 85) begin
      if (touched_rows.size() != 0 && $urandom_range(9) < 7) begin
        pick = $urandom_range(touched_rows.size() - 1);
        it = mk_read(touched_rows[pick], touched_cols[pick]);
      end else if ($urandom_range(9) == 0) begin
        it = mk_read($urandom_range(1023), $urandom_range(1023));
      end else begin
        it = mk_read($urandom_range(GRID - 1), $urandom_range(GRID - 1));
      end
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      it = raw[$bits(in_t)-1:0];
      if (it.req_type == REQ_CLEAR) it.req_type = REQ_READ;
    end
    return it;
  endfunction

  // result checker and receiver pacing
  initial forever begin
    out_t want;
    @(posedge clk_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reads.size() == 0) begin
        $display("%0t unexpected transfer row %0d col %0d", $time,
                 out_data_o.row_out, out_data_o.col_out);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (out_data_o.row_out !== want.row_out) begin
          $display("%0t row_out expected %0d actual %0d", $time, want.row_out,
                   out_data_o.row_out);
          errors++;
        end
        if (out_data_o.col_out !== want.col_out) begin
          $display("%0t col_out expected %0d actual %0d", $time, want.col_out,
                   out_data_o.col_out);
          errors++;
        end
        if (out_data_o.log_average !== want.log_average) begin
          $display("%0t log_average expected %h actual %h", $time, want.log_average,
                   out_data_o.log_average);
          errors++;
        end
        if (out_data_o.hit_count !== want.hit_count) begin
          $display("%0t hit_count expected %0d actual %0d", $time, want.hit_count,
                   out_data_o.hit_count);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || $urandom_range(99) >= 35;
    end
  end

  task automatic test_defaults();
    send(mk_read(0, 0));
    send(mk_read(GRID - 1, GRID - 1));
    send(mk_read(5, 7));
    send(mk_deposit(48'd0, 48'd0, 48'd0, 48'd0, 48'd100));
    send(mk_read(0, 0));
    drain();
  endtask

  task automatic test_directed();
    logic [47:0] c, h, pitch;
    in_t         it;
    c = 48'd128 << 40;
    h = 48'd1 << 40;
    pitch = 48'd1 << 32;
    send(mk_deposit(c, c, c, 48'd0, 48'd50_000_000_000));
    send(mk_read(256, 256));
    send(mk_deposit(c, c, c, 2 * pitch, '1));
    send(mk_read(254, 254));
    send(mk_read(258, 258));
    send(mk_read(259, 259));
    send(mk_deposit(c + h - 1, c, c - h + 1, 3 * pitch, 48'd7_000_000_000));
    send(mk_read(GRID - 1, 0));
    send(mk_deposit(c + h, c, c, pitch, 48'd1));
    send(mk_deposit(c, c - h, c, pitch, 48'd1));
    send(mk_deposit(48'd0, c, c, pitch, 48'd1));
    it = mk_read(3, 3);
    it.req_type = 2'd3;
    send(it);
    send(mk_read(GRID, 3));
    send(mk_read(3, 1023));
    send(mk_read(0, 0));
    send(mk_read(GRID - 1, GRID - 1));
    send(mk_deposit(c, c, c, 48'd0, 48'd0));
    send(mk_read(256, 256));
    it = '0;
    it.req_type = REQ_CLEAR;
    send(it);
    send(mk_read(256, 256));
    drain();
  endtask

  task automatic test_random(int n, bit with_clear);
    in_t it;
    if (with_clear) begin
      it = '0;
      it.req_type = REQ_CLEAR;
      send(it);
    end
    repeat (n) send(random_item());
    drain();
  endtask

  task automatic test_backpressure();
    hold_left = 3000;
    repeat (40) send(random_item());
    drain();
  endtask

  map_cfg_t c1, c2, c3, c4, c5;

  initial begin
    c1 = '{cx: 48'd128 << 40, cy: 48'd128 << 40, cz: 48'd128 << 40, hw: 48'd1 << 40,
           scale: 48'd256 << 24, lo: CLAMP_LOW_RST, hi: CLAMP_HIGH_RST, mode: 1'b0};
    c2 = '{cx: 48'd5 << 40, cy: 48'd9 << 40, cz: 48'd200 << 40, hw: 48'd1 << 39,
           scale: 48'd512 << 24, lo: '0, hi: '1, mode: 1'b1};
    c3 = '{cx: '1, cy: '1, cz: '1, hw: '1, scale: '0,
           lo: CLAMP_HIGH_RST, hi: CLAMP_LOW_RST, mode: 1'b0};
    c4 = '{cx: '0, cy: '0, cz: '0, hw: 48'd1 << 30, scale: '1,
           lo: 48'd1, hi: 48'd1 << 40, mode: 1'b0};
    c5 = '{cx: 48'd64 << 40, cy: 48'd3 << 40, cz: 48'd64 << 40, hw: 48'd1 << 38,
           scale: 48'd1024 << 24, lo: 48'd1000, hi: 48'd1 << 45, mode: 1'b1};
    cfg = '{cx: '0, cy: '0, cz: '0, hw: '0, scale: '0,
            lo: CLAMP_LOW_RST, hi: CLAMP_HIGH_RST, mode: 1'b0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    set_config(c1);
    test_directed();
    no_idle = 1;
    test_random(400, 0);
    no_idle = 0;
    test_backpressure();
    set_config(c2);
    test_random(400, 0);
    set_config(c3);
    test_random(400, 1);
    set_config(c4);
    test_random(400, 0);
    set_config(c5);
    test_random(400, 0);
    repeat (300) @(posedge clk_i);
    if (pending_reads.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_reads.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
